@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the condition holds at an edge, the expression must hold at the same edge.
`define BCQ_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// When the condition holds at an edge, the expression must hold at the next edge.
`define BCQ_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ rtl/core/bcq_pkg.sv @@
package bcq_pkg;

   // Field widths.
   localparam int RATE_W  = 24;
   localparam int BACK_W  = 22;
   localparam int CLASS_W = 8;
   localparam int DIFF_W  = 24;

   // Download candidate set: two mantissas times sixteen exponents.
   localparam int EXP_N  = 16;
   localparam int CAND_N = 2 * EXP_N;
   localparam int IDX_W  = $clog2(CAND_N);

   // Download candidates left after the first reduction stage.
   localparam int POOL_N = 8;

   // Upload fractions in eighths of the download rate.
   localparam int UP_N   = 8;
   localparam int U_W    = $clog2(UP_N);
   localparam int PROD_W = BACK_W + U_W + 1;

   // Class byte fields and the class that decodes to zero rates.
   localparam logic [CLASS_W-1:0] CLASS_DOWN_MASK = 8'hF8;
   localparam logic [CLASS_W-1:0] CLASS_SPEED_BIT = 8'h80;
   localparam logic [CLASS_W-1:0] CLASS_EXP_MASK  = 8'h78;
   localparam logic [CLASS_W-1:0] CLASS_UP_MASK   = 8'h07;
   localparam logic [CLASS_W-1:0] CLASS_ZERO      = 8'h00;

   // Mantissas of the two download candidate rows.
   localparam logic [BACK_W-1:0] BASE_SLOW = 22'd64;
   localparam logic [BACK_W-1:0] BASE_FAST = 22'd96;

   // Coarse search result: the winning download index and the upload request.
   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [RATE_W-1:0] up_kbit;
   } bcq_coarse_type;

   // Final pick: class byte and the two candidate rates behind it.
   typedef struct packed {
      logic [CLASS_W-1:0] gw_class;
      logic [BACK_W-1:0]  down_kbit;
      logic [BACK_W-1:0]  up_kbit;
   } bcq_pick_type;

   // Download rate of a candidate index; the top bit selects the mantissa.
   function automatic logic [BACK_W-1:0] down_cand(input logic [IDX_W-1:0] idx);
      logic [BACK_W-1:0] base;
      base = idx[IDX_W-1] ? BASE_FAST : BASE_SLOW;
      return base << idx[IDX_W-2:0];
   endfunction

   // Absolute difference of two rates.
   function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] a,
                                                  input logic [DIFF_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ rtl/core/bcq_stream_if.sv @@
// Request channel: the two requested rates.
interface bcq_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] down_kbit;
   logic [23:0] up_kbit;

   modport source (output valid, output down_kbit, output up_kbit, input ready);
   modport sink   (input valid, input down_kbit, input up_kbit, output ready);
endinterface

// Response channel: class byte and the decoded rates.
interface bcq_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  gw_class;
   logic [21:0] down_back_kbit;
   logic [21:0] up_back_kbit;

   modport source (output valid, output gw_class, output down_back_kbit,
                   output up_back_kbit, input ready);
   modport sink   (input valid, input gw_class, input down_back_kbit,
                   input up_back_kbit, output ready);
endinterface

@@ rtl/core/bcq_down_search.sv @@
// Two-stage nearest search over the 32 download candidates.
module bcq_down_search (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [23:0]             down_kbit,
   input  logic [23:0]             up_kbit,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bcq_pkg::bcq_coarse_type out_data
);
   import bcq_pkg::*;

   localparam int L1_N = CAND_N / 2;

   logic [DIFF_W-1:0] cand_diff [CAND_N];
   logic [DIFF_W-1:0] l1_diff   [L1_N];
   logic [IDX_W-1:0]  l1_idx    [L1_N];
   logic [DIFF_W-1:0] l2_diff   [POOL_N];
   logic [IDX_W-1:0]  l2_idx    [POOL_N];

   logic              s1_valid_ff, s1_valid_in;
   logic [DIFF_W-1:0] s1_diff_ff [POOL_N];
   logic [IDX_W-1:0]  s1_idx_ff  [POOL_N];
   logic [RATE_W-1:0] s1_up_ff;
   logic              s1_adv;

   logic [DIFF_W-1:0] m1_diff [POOL_N/2];
   logic [IDX_W-1:0]  m1_idx  [POOL_N/2];
   logic [DIFF_W-1:0] m2_diff [POOL_N/4];
   logic [IDX_W-1:0]  m2_idx  [POOL_N/4];
   logic [IDX_W-1:0]  win_idx;

   logic              s2_valid_ff, s2_valid_in;
   bcq_coarse_type    s2_data_ff;
   logic              s2_adv;

   // Stall control: a stage loads when it is empty or its successor moves.
   assign s2_adv      = !s2_valid_ff || out_ready;
   assign s1_adv      = !s1_valid_ff || s2_adv;
   assign in_ready    = s1_adv;
   assign s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;

   // Stage 1: distance to every candidate, then two pairwise levels.
   // The earlier candidate is kept unless the later one is strictly nearer.
   always_comb begin
      for (int i = 0; i < CAND_N; i++) begin
         cand_diff[i] = abs_diff(DIFF_W'(down_cand(IDX_W'(i))), down_kbit);
      end
      for (int i = 0; i < L1_N; i++) begin
         if (cand_diff[2*i+1] < cand_diff[2*i]) begin
            l1_diff[i] = cand_diff[2*i+1];
            l1_idx[i]  = IDX_W'(2*i+1);
         end else begin
            l1_diff[i] = cand_diff[2*i];
            l1_idx[i]  = IDX_W'(2*i);
         end
      end
      for (int i = 0; i < POOL_N; i++) begin
         if (l1_diff[2*i+1] < l1_diff[2*i]) begin
            l2_diff[i] = l1_diff[2*i+1];
            l2_idx[i]  = l1_idx[2*i+1];
         end else begin
            l2_diff[i] = l1_diff[2*i];
            l2_idx[i]  = l1_idx[2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_adv) begin
         for (int i = 0; i < POOL_N; i++) begin
            s1_diff_ff[i] <= l2_diff[i];
            s1_idx_ff[i]  <= l2_idx[i];
         end
         s1_up_ff <= up_kbit;
      end
   end

   // Stage 2: reduce the remaining eight in three levels.
   always_comb begin
      for (int i = 0; i < POOL_N/2; i++) begin
         if (s1_diff_ff[2*i+1] < s1_diff_ff[2*i]) begin
            m1_diff[i] = s1_diff_ff[2*i+1];
            m1_idx[i]  = s1_idx_ff[2*i+1];
         end else begin
            m1_diff[i] = s1_diff_ff[2*i];
            m1_idx[i]  = s1_idx_ff[2*i];
         end
      end
      for (int i = 0; i < POOL_N/4; i++) begin
         if (m1_diff[2*i+1] < m1_diff[2*i]) begin
            m2_diff[i] = m1_diff[2*i+1];
            m2_idx[i]  = m1_idx[2*i+1];
         end else begin
            m2_diff[i] = m1_diff[2*i];
            m2_idx[i]  = m1_idx[2*i];
         end
      end
      win_idx = (m2_diff[1] < m2_diff[0]) ? m2_idx[1] : m2_idx[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s2_adv) begin
         s2_data_ff.idx     <= win_idx;
         s2_data_ff.up_kbit <= s1_up_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

@@ rtl/core/bcq_up_search.sv @@
// One stage: upload fractions of the chosen download rate and their nearest pick.
module bcq_up_search (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  bcq_pkg::bcq_coarse_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bcq_pkg::bcq_pick_type   out_data
);
   import bcq_pkg::*;

   logic [BACK_W-1:0] down_rate;
   logic [PROD_W-1:0] prod      [UP_N];
   logic [BACK_W-1:0] up_cand   [UP_N];
   logic [DIFF_W-1:0] up_diff   [UP_N];
   logic [DIFF_W-1:0] t1_diff   [UP_N/2];
   logic [U_W-1:0]    t1_u      [UP_N/2];
   logic [DIFF_W-1:0] t2_diff   [UP_N/4];
   logic [U_W-1:0]    t2_u      [UP_N/4];
   logic [U_W-1:0]    win_u;

   logic              valid_ff, valid_in;
   bcq_pick_type      data_ff;
   logic              adv;

   assign adv      = !valid_ff || out_ready;
   assign in_ready = adv;
   assign valid_in = adv ? in_valid : valid_ff;

   // Candidate k is (k+1)/8 of the download rate; the rate is a multiple of 32.
   always_comb begin
      down_rate = down_cand(in_data.idx);
      for (int k = 0; k < UP_N; k++) begin
         prod[k]    = PROD_W'(down_rate) * PROD_W'(k + 1);
         up_cand[k] = prod[k][BACK_W+U_W-1:U_W];
         up_diff[k] = abs_diff(DIFF_W'(up_cand[k]), in_data.up_kbit);
      end
      // Nearest fraction; the smaller fraction wins a tie.
      for (int i = 0; i < UP_N/2; i++) begin
         if (up_diff[2*i+1] < up_diff[2*i]) begin
            t1_diff[i] = up_diff[2*i+1];
            t1_u[i]    = U_W'(2*i+1);
         end else begin
            t1_diff[i] = up_diff[2*i];
            t1_u[i]    = U_W'(2*i);
         end
      end
      for (int i = 0; i < UP_N/4; i++) begin
         if (t1_diff[2*i+1] < t1_diff[2*i]) begin
            t2_diff[i] = t1_diff[2*i+1];
            t2_u[i]    = t1_u[2*i+1];
         end else begin
            t2_diff[i] = t1_diff[2*i];
            t2_u[i]    = t1_u[2*i];
         end
      end
      win_u = (t2_diff[1] < t2_diff[0]) ? t2_u[1] : t2_u[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv) begin
         data_ff.gw_class  <= {in_data.idx, win_u};
         data_ff.down_kbit <= down_rate;
         data_ff.up_kbit   <= up_cand[win_u];
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ rtl/core/bandwidth_class_quantizer_top.sv @@
// A request passes through every register stage below before its response can transfer.
// Throughput: one request per cycle; a stall on the response side holds every stage
// and bubbles close up, so the request side keeps moving until the pipeline is full.
// Four register stages: two for the download search, one for the upload search,
// and the response register. Reset clears the stage valid bits only.
module bandwidth_class_quantizer_top (
   input  logic       clock,
   input  logic       reset,
   bcq_req_if.sink    req_ch,
   bcq_rsp_if.source  rsp_ch
);
   import bcq_pkg::*;

`include "assert_macros.svh"

   logic           coarse_valid, coarse_ready;
   bcq_coarse_type coarse_data;
   logic           pick_valid, pick_ready;
   bcq_pick_type   pick_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0] rsp_class_ff;
   logic [BACK_W-1:0]  rsp_down_ff, rsp_up_ff;
   logic               rsp_adv;
   logic               class_is_zero;

   bcq_down_search u_down (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .down_kbit (req_ch.down_kbit),
      .up_kbit   (req_ch.up_kbit),
      .out_valid (coarse_valid),
      .out_ready (coarse_ready),
      .out_data  (coarse_data)
   );

   bcq_up_search u_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (coarse_valid),
      .in_ready  (coarse_ready),
      .in_data   (coarse_data),
      .out_valid (pick_valid),
      .out_ready (pick_ready),
      .out_data  (pick_data)
   );

   // Response register; the all-zero class decodes to zero rates.
   assign rsp_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign pick_ready    = rsp_adv;
   assign rsp_valid_in  = rsp_adv ? pick_valid : rsp_valid_ff;
   assign class_is_zero = (pick_data.gw_class == CLASS_ZERO);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_adv) begin
         rsp_class_ff <= pick_data.gw_class;
         rsp_down_ff  <= class_is_zero ? '0 : pick_data.down_kbit;
         rsp_up_ff    <= class_is_zero ? '0 : pick_data.up_kbit;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.gw_class       = rsp_class_ff;
   assign rsp_ch.down_back_kbit = rsp_down_ff;
   assign rsp_ch.up_back_kbit   = rsp_up_ff;

   // The zero class always reports zero rates.
   `BCQ_ASSERT_SAME(a_zero_class, clock, reset, rsp_valid_ff && (rsp_class_ff == CLASS_ZERO), (rsp_down_ff == '0) && (rsp_up_ff == '0), "zero class with nonzero rates")

   // Any other class carries a nonzero download rate at least as large as the upload rate.
   `BCQ_ASSERT_SAME(a_rate_order, clock, reset, rsp_valid_ff && (rsp_class_ff != CLASS_ZERO), (rsp_down_ff != '0) && (rsp_up_ff <= rsp_down_ff), "decoded rates out of order")

   // A pick that the response register cannot take must still be there next cycle.
   `BCQ_ASSERT_NEXT(a_pick_held, clock, reset, pick_valid && !pick_ready, pick_valid && $stable(pick_data), "stalled pick lost or changed")

endmodule

@@ dv/bandwidth_class_quantizer_top_tb.sv @@
module bandwidth_class_quantizer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bcq_pkg::*;

   // Run shape.
   localparam int unsigned DIFF_START   = 32'h0FFF_FFFF;
   localparam int          PHASE_N      = 4;
   localparam int          PHASE_ITEMS  = 363;
   localparam int          HOLD_AFTER   = 64;
   localparam int          HOLD_CYCLES  = 60;
   localparam int          QUIET_LIMIT  = 2000;
   localparam int          SETTLE_WAIT  = 12;
   localparam int          PRINT_LIMIT  = 40;

   // Sender idle and receiver stall odds, in percent, per phase.
   localparam int PHASE_IDLE  [PHASE_N] = '{0, 78, 0, 37};
   localparam int PHASE_STALL [PHASE_N] = '{0, 0, 78, 37};

   typedef struct {
      logic [RATE_W-1:0] down_kbit;
      logic [RATE_W-1:0] up_kbit;
      int                idle_pct;
      int                stall_pct;
      bit                drain_first;
   } rate_request_type;

   typedef struct {
      logic [CLASS_W-1:0] gw_class;
      logic [BACK_W-1:0]  down_back;
      logic [BACK_W-1:0]  up_back;
   } class_result_type;

   logic clock;
   logic reset = 1'b1;

   bcq_req_if req_ch ();
   bcq_rsp_if rsp_ch ();

   bandwidth_class_quantizer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rate_request_type pending_requests[$];
   class_result_type expected_classes[$];

   rate_request_type next_request;
   class_result_type seen_class;
   class_result_type want_class;
   bit            req_taken;
   bit            hold_done;
   int            hold_left;
   int            rsp_stall_pct;
   int            queued_requests;
   int            accepted_requests;
   int            checked_responses;
   int            zero_class_count;
   int            mismatch_count;
   int            quiet_cycles;

   // Clock generation.
   always begin
      clock = 1'b0;
      #5ns;
      clock = 1'b1;
      #5ns;
   end

   // Distance between two rates.
   function automatic int unsigned rate_distance(input int unsigned a, input int unsigned b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Download rate for a mantissa select and an exponent.
   function automatic int unsigned download_rate(input int unsigned fast,
                                                 input int unsigned expo);
      return (32 * (fast + 2)) << expo;
   endfunction

   // Class byte of the nearest download candidate, upload part left at zero.
   // The scan runs over the slow row first, and the first candidate wins a tie.
   function automatic logic [CLASS_W-1:0] nearest_download(input int unsigned want);
      int unsigned        best;
      int unsigned        diff;
      logic [CLASS_W-1:0] cls;
      best = DIFF_START;
      cls  = CLASS_ZERO;
      for (int fast = 0; fast < 2; fast++) begin
         for (int expo = 0; expo < EXP_N; expo++) begin
            diff = rate_distance(download_rate(fast, expo), want);
            if (diff < best) begin
               best = diff;
               cls  = {fast[0], expo[3:0], 3'b000};
            end
         end
      end
      return cls;
   endfunction

   // Full quantization: download pick, upload eighth pick, then decode back.
   function automatic class_result_type predict_class(input logic [RATE_W-1:0] down_kbit,
                                                      input logic [RATE_W-1:0] up_kbit);
      class_result_type   result;
      logic [CLASS_W-1:0] cls;
      int unsigned        down_rate;
      int unsigned        best;
      int unsigned        diff;
      cls       = nearest_download(32'(down_kbit));
      down_rate = download_rate(32'(cls[7]), 32'(cls[6:3]));
      best      = DIFF_START;
      for (int u = 0; u < UP_N; u++) begin
         diff = rate_distance(((u + 1) * down_rate) / 8, 32'(up_kbit));
         if (diff < best) begin
            best     = diff;
            cls[2:0] = u[2:0];
         end
      end
      result.gw_class = cls;
      // The all-zero class decodes to zero rates, not to the smallest candidate.
      if (cls == CLASS_ZERO) begin
         result.down_back = '0;
         result.up_back   = '0;
      end else begin
         result.down_back = BACK_W'(down_rate);
         result.up_back   = BACK_W'(((int'(cls[2:0]) + 1) * down_rate) / 8);
      end
      return result;
   endfunction

   // Random request, mostly placed on or between candidates to hit ties.
   function automatic rate_request_type random_request();
      rate_request_type r;
      int unsigned   pick;
      int unsigned   fast;
      int unsigned   expo;
      int unsigned   rate;
      int unsigned   above;
      int unsigned   base;
      int unsigned   step;
      logic [CLASS_W-1:0] cls;
      pick  = $urandom_range(99);
      fast  = $urandom_range(1);
      expo  = $urandom_range(EXP_N - 1);
      rate  = download_rate(fast, expo);
      above = fast ? download_rate(0, expo + 1) : download_rate(1, expo);
      r.idle_pct    = 0;
      r.stall_pct   = 0;
      r.drain_first = 1'b0;
      if (pick < 25) begin
         r.down_kbit = RATE_W'($urandom);
         r.up_kbit   = RATE_W'($urandom);
      end else if (pick < 40) begin
         r.down_kbit = RATE_W'($urandom_range(200));
         r.up_kbit   = RATE_W'($urandom_range(40));
      end else begin
         case ($urandom_range(3))
            0: r.down_kbit = RATE_W'(rate);
            1: r.down_kbit = RATE_W'((rate + above) / 2);
            2: r.down_kbit = RATE_W'(rate + $urandom_range(8) - 4);
            default: r.down_kbit = RATE_W'((rate + above) / 2 + $urandom_range(2) - 1);
         endcase
         cls  = nearest_download(32'(r.down_kbit));
         base = download_rate(32'(cls[7]), 32'(cls[6:3]));
         step = base / 8;
         case ($urandom_range(3))
            0: r.up_kbit = RATE_W'(step * $urandom_range(1, 8));
            1: r.up_kbit = RATE_W'(step * $urandom_range(1, 7) + step / 2);
            2: r.up_kbit = RATE_W'(step * $urandom_range(8) + $urandom_range(3));
            default: r.up_kbit = RATE_W'($urandom_range(2 * base));
         endcase
      end
      return r;
   endfunction

   // Add one request to the stimulus queue.
   task automatic queue_request(input int unsigned down_kbit, input int unsigned up_kbit,
                                input bit drain_first);
      rate_request_type r;
      r.down_kbit   = RATE_W'(down_kbit);
      r.up_kbit     = RATE_W'(up_kbit);
      r.idle_pct    = 0;
      r.stall_pct   = 0;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endtask

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // Request driver: offer the next queued item when the previous one transferred.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.down_kbit <= '0;
         req_ch.up_kbit   <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_requests.size() != 0 &&
             !(pending_requests[0].drain_first && expected_classes.size() != 0) &&
             $urandom_range(99) >= pending_requests[0].idle_pct) begin
            next_request      = pending_requests.pop_front();
            rsp_stall_pct     = next_request.stall_pct;
            req_ch.valid     <= 1'b1;
            req_ch.down_kbit <= next_request.down_kbit;
            req_ch.up_kbit   <= next_request.up_kbit;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stalls, plus one long hold once traffic is flowing.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && accepted_requests >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: predict on each request transfer, check each response transfer.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            accepted_requests++;
            expected_classes.push_back(predict_class(req_ch.down_kbit, req_ch.up_kbit));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_class.gw_class  = rsp_ch.gw_class;
            seen_class.down_back = rsp_ch.down_back_kbit;
            seen_class.up_back   = rsp_ch.up_back_kbit;
            if (expected_classes.size() == 0) begin
               report_mismatch($sformatf("response class %0d with no request outstanding",
                                         seen_class.gw_class));
            end else begin
               want_class = expected_classes.pop_front();
               checked_responses++;
               if (want_class.gw_class == CLASS_ZERO) zero_class_count++;
               if (seen_class.gw_class != want_class.gw_class)
                  report_mismatch($sformatf("gw_class %0d, expected %0d",
                                            seen_class.gw_class, want_class.gw_class));
               if (seen_class.down_back != want_class.down_back)
                  report_mismatch($sformatf("down_back_kbit %0d, expected %0d",
                                            seen_class.down_back, want_class.down_back));
               if (seen_class.up_back != want_class.up_back)
                  report_mismatch($sformatf("up_back_kbit %0d, expected %0d",
                                            seen_class.up_back, want_class.up_back));
            end
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT) begin
               $display("Timeout: no transfer in %0d cycles", QUIET_LIMIT);
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      rate_request_type r;

      // Directed: zero class, ties on both searches, field extremes.
      queue_request(0, 0, 1'b1);
      queue_request(0, 12, 1'b0);
      queue_request(0, 13, 1'b0);
      queue_request(1, 1, 1'b0);
      queue_request(80, 0, 1'b0);
      queue_request(112, 0, 1'b0);
      queue_request(64, 8, 1'b0);
      queue_request(96, 12, 1'b0);
      queue_request(96, 18, 1'b0);
      queue_request(1024, 192, 1'b0);
      queue_request(2097152, 1048576, 1'b0);
      queue_request(3145728, 3145728, 1'b0);
      queue_request(3670016, 1572864, 1'b0);
      queue_request('hFFFFFF, 'hFFFFFF, 1'b0);
      queue_request('hFFFFFF, 0, 1'b0);
      queue_request(0, 'hFFFFFF, 1'b0);
      queue_request('hAAAAAA, 'h555555, 1'b0);
      queue_request('h555555, 'hAAAAAA, 1'b0);

      // Random phases, each opening on an empty pipeline; one extra drain mid-run.
      for (int phase = 0; phase < PHASE_N; phase++) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r             = random_request();
            r.idle_pct    = PHASE_IDLE[phase];
            r.stall_pct   = PHASE_STALL[phase];
            r.drain_first = (i == 0) || (phase == 2 && i == PHASE_ITEMS / 2);
            pending_requests.push_back(r);
         end
      end
      queued_requests = pending_requests.size();

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_requests != queued_requests || expected_classes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);

      if (expected_classes.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_classes.size()));
      $display("Quantized %0d rate pairs (%0d to the zero class) over four timing phases,",
               checked_responses, zero_class_count);
      $display("with a long response hold and pipeline drains between phases.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bcq_pkg.sv
rtl/core/bcq_stream_if.sv
rtl/core/bcq_down_search.sv
rtl/core/bcq_up_search.sv
rtl/core/bandwidth_class_quantizer_top.sv
dv/bandwidth_class_quantizer_top_tb.sv
